// File: src/grid_water_volume_accumulator_macros.svh
`ifndef GRID_WATER_VOLUME_ACCUMULATOR_MACROS_SVH
`define GRID_WATER_VOLUME_ACCUMULATOR_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define GWVA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define GWVA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/gwva_pkg.sv
`default_nettype none

package gwva_pkg;

    localparam int StepW = 6;

    localparam logic [StepW-1:0] PcChanTail = 6'd19;
    localparam logic [StepW-1:0] PcOvl      = 6'd34;
    localparam logic [StepW-1:0] PcFin      = 6'd41;

    localparam logic [63:0] SatMag = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SatMin = 64'h8000_0000_0000_0000;

    localparam logic [1:0] CfgCellSize   = 2'd0;
    localparam logic [1:0] CfgChanEnable = 2'd1;
    localparam logic [1:0] CfgNoData     = 2'd2;

    localparam logic [31:0] CellSizeReset = 32'h0001_0000;
    localparam logic [31:0] NoDataReset   = 32'hFFFF_D8F1;

    typedef enum logic [2:0] {
        A_D24,
        A_DCH24,
        A_H24,
        A_HALF,
        A_AREA,
        A_TW,
        A_P
    } t_asel;

    typedef enum logic [2:0] {
        B_D,
        B_SS,
        B_W,
        B_LF,
        B_H,
        B_EXC
    } t_bsel;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI,
        MUL_WB
    } t_mul_op;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_HALF,
        ALU_AREA,
        ALU_TW_DBL,
        ALU_TW_WCH,
        ALU_AREA_ADD,
        ALU_CH_ACC,
        ALU_DIFF,
        ALU_OV_ACC,
        ALU_FIN
    } t_alu_op;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NODATA,
        COND_NOTCHAN,
        COND_BELOW
    } t_cond;

    typedef struct packed {
        t_asel            a_sel;
        t_bsel            b_sel;
        t_mul_op          mul;
        t_alu_op          alu;
        t_cond            cond;
        logic [StepW-1:0] target;
    } t_uop;

    typedef struct packed {
        logic nodata;
        logic notchan;
        logic below;
    } t_status;

    function automatic t_uop mk_uop(input t_asel a, input t_bsel b, input t_mul_op m,
                                    input t_alu_op al, input t_cond c,
                                    input logic [StepW-1:0] tgt);
        t_uop u;
        u.a_sel  = a;
        u.b_sel  = b;
        u.mul    = m;
        u.alu    = al;
        u.cond   = c;
        u.target = tgt;
        return u;
    endfunction

    function automatic t_uop prog_rom(input logic [StepW-1:0] pc);
        t_uop u;
        case (pc)
            // dispatch
            6'd0:  u = mk_uop(A_D24, B_D, MUL_NONE, ALU_NONE, COND_NODATA, PcFin);
            6'd1:  u = mk_uop(A_D24, B_D, MUL_NONE, ALU_NONE, COND_NOTCHAN, PcOvl);
            // half width = bottom + d * slope
            6'd2:  u = mk_uop(A_D24, B_SS, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd3:  u = mk_uop(A_D24, B_SS, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd4:  u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd5:  u = mk_uop(A_D24, B_D, MUL_NONE, ALU_HALF, COND_NONE, PcFin);
            // area = half * d
            6'd6:  u = mk_uop(A_HALF, B_D, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd7:  u = mk_uop(A_HALF, B_D, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd8:  u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd9:  u = mk_uop(A_D24, B_D, MUL_NONE, ALU_AREA, COND_NONE, PcFin);
            // bank-top width
            6'd10: u = mk_uop(A_DCH24, B_SS, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd11: u = mk_uop(A_DCH24, B_SS, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd12: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd13: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_TW_DBL, COND_NONE, PcFin);
            6'd14: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_TW_WCH, COND_BELOW, PcChanTail);
            // rectangle above bank
            6'd15: u = mk_uop(A_TW, B_EXC, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd16: u = mk_uop(A_TW, B_EXC, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd17: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd18: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_AREA_ADD, COND_NONE, PcFin);
            // channel volume
            6'd19: u = mk_uop(A_AREA, B_W, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd20: u = mk_uop(A_AREA, B_W, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd21: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd22: u = mk_uop(A_P, B_LF, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd23: u = mk_uop(A_P, B_LF, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd24: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd25: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_CH_ACC, COND_NONE, PcFin);
            // overland part of a channel cell
            6'd26: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_DIFF, COND_NONE, PcFin);
            6'd27: u = mk_uop(A_HALF, B_W, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd28: u = mk_uop(A_HALF, B_W, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd29: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd30: u = mk_uop(A_P, B_H, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd31: u = mk_uop(A_P, B_H, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd32: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd33: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_OV_ACC, COND_ALWAYS, PcFin);
            // plain overland cell
            6'd34: u = mk_uop(A_H24, B_W, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd35: u = mk_uop(A_H24, B_W, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd36: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd37: u = mk_uop(A_P, B_W, MUL_LO, ALU_NONE, COND_NONE, PcFin);
            6'd38: u = mk_uop(A_P, B_W, MUL_HI, ALU_NONE, COND_NONE, PcFin);
            6'd39: u = mk_uop(A_D24, B_D, MUL_WB, ALU_NONE, COND_NONE, PcFin);
            6'd40: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_OV_ACC, COND_NONE, PcFin);
            // emit and clear on last cell
            6'd41: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_FIN, COND_NONE, PcFin);
            default: u = mk_uop(A_D24, B_D, MUL_NONE, ALU_FIN, COND_NONE, PcFin);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: src/gwva_mul.sv
`default_nettype none

module gwva_mul (
    input  wire                     i_clk,
    input  wire gwva_pkg::t_mul_op  i_op,
    input  wire logic [63:0]        i_a,
    input  wire logic [31:0]        i_b,
    output logic [63:0]             o_p
);
    import gwva_pkg::*;

    logic [31:0] mul_x;
    logic [63:0] prod;
    logic [63:0] r_plo;
    logic [63:0] r_phi;
    logic [63:0] r_p;
    logic [63:0] n_p;
    logic [63:0] comb_sum;

    assign mul_x = (i_op == MUL_HI) ? i_a[63:32] : i_a[31:0];
    assign prod  = mul_x * i_b;

    always_comb begin
        comb_sum = {r_phi[47:0], 16'b0} + {16'b0, r_plo[63:16]};
        if (r_phi[63:47] != 17'b0) begin
            n_p = SatMag;
        end else if (comb_sum[63]) begin
            n_p = SatMag;
        end else begin
            n_p = comb_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            MUL_LO: r_plo <= prod;
            MUL_HI: r_phi <= prod;
            MUL_WB: r_p <= n_p;
            default: ;
        endcase
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// File: src/gwva_seq.sv
`default_nettype none

module gwva_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire                 i_hold,
    input  wire gwva_pkg::t_status i_status,
    output gwva_pkg::t_uop      o_uop,
    output logic                o_busy
);
    import gwva_pkg::*;

    logic [StepW-1:0] r_pc;
    logic [StepW-1:0] n_pc;
    logic             r_busy;
    logic             n_busy;
    logic             cond_true;
    t_uop             uop;

    assign uop = prog_rom(r_pc);

    always_comb begin
        case (uop.cond)
            COND_ALWAYS:  cond_true = 1'b1;
            COND_NODATA:  cond_true = i_status.nodata;
            COND_NOTCHAN: cond_true = i_status.notchan;
            COND_BELOW:   cond_true = i_status.below;
            default:      cond_true = 1'b0;
        endcase
    end

    always_comb begin
        n_pc   = r_pc;
        n_busy = r_busy;
        if (!r_busy) begin
            if (i_start) begin
                n_pc   = '0;
                n_busy = 1'b1;
            end
        end else if (!i_hold) begin
            if (uop.alu == ALU_FIN) begin
                n_busy = 1'b0;
            end else if (cond_true) begin
                n_pc = uop.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_busy <= 1'b0;
        end else begin
            r_pc   <= n_pc;
            r_busy <= n_busy;
        end
    end

    assign o_uop  = uop;
    assign o_busy = r_busy;

endmodule

`default_nettype wire

// File: src/grid_water_volume_accumulator.sv
`default_nettype none

// Grid water volume accumulator. One grid cell is taken per transaction and
// its stored water is added to a channel sum and an overland sum (signed
// Q40.24, saturating); the cell flagged last_cell releases one result with
// both sums and clears them. Depths, widths, slope, length factor and
// cell_size are unsigned Q16.16. One shared 32x32 multiplier, driven by a
// microprogram in low, high and writeback steps per Q40.24-by-Q16.16 product,
// sets the pace: no cell is accepted while busy; a channel cell takes longest
// (less when water stays below bank depth), a no-data cell shortest. A last
// cell waits further while an earlier result is still held by a stalled
// output; else the output register lets the next cell in while the result waits.
// Configuration must be written only while idle; the block does not enforce it.

module grid_water_volume_accumulator (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [31:0]    i_cfg_data,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire logic signed [31:0] i_mask_value,
    input  wire logic [15:0]    i_link_number,
    input  wire logic [31:0]    i_overland_depth,
    input  wire logic [31:0]    i_channel_depth,
    input  wire logic [31:0]    i_bottom_width,
    input  wire logic [31:0]    i_bank_depth,
    input  wire logic [31:0]    i_side_slope,
    input  wire logic [31:0]    i_length_factor,
    input  wire                 i_last_cell,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic signed [63:0]  o_channel_volume,
    output logic signed [63:0]  o_overland_volume
);
    import gwva_pkg::*;

    function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
        logic [63:0] s;
        s = x + y;
        return s[63] ? SatMag : s;
    endfunction

    function automatic logic [63:0] acc_add(input logic [63:0] s, input logic [63:0] m);
        logic [64:0] t;
        t = {s[63], s} + {1'b0, m};
        return (!t[64] && t[63]) ? SatMag : t[63:0];
    endfunction

    function automatic logic [63:0] acc_sub(input logic [63:0] s, input logic [63:0] m);
        logic [64:0] t;
        t = {s[63], s} - {1'b0, m};
        return (t[64] && !t[63]) ? SatMin : t[63:0];
    endfunction

    // configuration
    logic [31:0]        r_cell_size;
    logic               r_chan_en;
    logic signed [31:0] r_no_data;

    // captured cell
    logic signed [31:0] r_mask;
    logic [15:0]        r_link;
    logic [31:0]        r_h;
    logic [31:0]        r_hch;
    logic [31:0]        r_wch;
    logic [31:0]        r_dch;
    logic [31:0]        r_ss;
    logic [31:0]        r_lf;
    logic               r_last;

    // working registers
    logic [63:0] r_half;
    logic [63:0] r_area;
    logic [63:0] r_tw;
    logic        r_neg;

    logic [63:0] r_ch_sum;
    logic [63:0] r_ov_sum;
    logic [63:0] n_ch_sum;
    logic [63:0] n_ov_sum;
    logic [63:0] r_out_ch;
    logic [63:0] r_out_ov;
    logic        r_ovalid;
    logic        n_ovalid;

    t_uop        uop;
    t_status     status;
    t_mul_op     mul_op;
    logic        busy;
    logic        in_accept;
    logic        hold;
    logic        fin_fire;
    logic        out_load;

    logic [31:0] d_min;
    logic [31:0] exc;
    logic [63:0] wch24;
    logic [63:0] w24;
    logic [63:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    assign in_accept = i_valid && !o_stall;
    assign o_stall   = busy;

    assign d_min = (r_hch < r_dch) ? r_hch : r_dch;
    assign exc   = r_hch - r_dch;
    assign wch24 = {24'b0, r_wch, 8'b0};
    assign w24   = {24'b0, r_cell_size, 8'b0};

    assign status.nodata  = (r_mask == r_no_data);
    assign status.notchan = !(r_chan_en && (r_link != 16'd0));
    assign status.below   = (r_hch < r_dch);

    assign hold     = busy && (uop.alu == ALU_FIN) && r_last && r_ovalid && i_stall;
    assign fin_fire = busy && (uop.alu == ALU_FIN) && !hold;
    assign out_load = fin_fire && r_last;
    assign mul_op   = busy ? uop.mul : MUL_NONE;

    gwva_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_accept),
        .i_hold   (hold),
        .i_status (status),
        .o_uop    (uop),
        .o_busy   (busy)
    );

    always_comb begin
        case (uop.a_sel)
            A_D24:   mul_a = {24'b0, d_min, 8'b0};
            A_DCH24: mul_a = {24'b0, r_dch, 8'b0};
            A_H24:   mul_a = {24'b0, r_h, 8'b0};
            A_HALF:  mul_a = r_half;
            A_AREA:  mul_a = r_area;
            A_TW:    mul_a = r_tw;
            A_P:     mul_a = mul_p;
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (uop.b_sel)
            B_D:     mul_b = d_min;
            B_SS:    mul_b = r_ss;
            B_W:     mul_b = r_cell_size;
            B_LF:    mul_b = r_lf;
            B_H:     mul_b = r_h;
            B_EXC:   mul_b = exc;
            default: mul_b = '0;
        endcase
    end

    gwva_mul u_mul (
        .i_clk (i_clk),
        .i_op  (mul_op),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= CellSizeReset;
            r_chan_en   <= 1'b0;
            r_no_data   <= NoDataReset;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgCellSize:   r_cell_size <= i_cfg_data;
                CfgChanEnable: r_chan_en   <= i_cfg_data[0];
                CfgNoData:     r_no_data   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mask <= i_mask_value;
            r_link <= i_link_number;
            r_h    <= i_overland_depth;
            r_hch  <= i_channel_depth;
            r_wch  <= i_bottom_width;
            r_dch  <= i_bank_depth;
            r_ss   <= i_side_slope;
            r_lf   <= i_length_factor;
            r_last <= i_last_cell;
            r_neg  <= 1'b0;
        end else if (busy) begin
            case (uop.alu)
                ALU_HALF:     r_half <= sat_add(wch24, mul_p);
                ALU_AREA:     r_area <= mul_p;
                ALU_TW_DBL:   r_tw   <= sat_add(mul_p, mul_p);
                ALU_TW_WCH:   r_tw   <= sat_add(r_tw, wch24);
                ALU_AREA_ADD: r_area <= sat_add(r_area, mul_p);
                ALU_DIFF: begin
                    if (w24 >= r_tw) begin
                        r_half <= w24 - r_tw;
                        r_neg  <= 1'b0;
                    end else begin
                        r_half <= r_tw - w24;
                        r_neg  <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ch_sum = r_ch_sum;
        n_ov_sum = r_ov_sum;
        if (busy) begin
            case (uop.alu)
                ALU_CH_ACC: n_ch_sum = acc_add(r_ch_sum, mul_p);
                ALU_OV_ACC: n_ov_sum = r_neg ? acc_sub(r_ov_sum, mul_p)
                                             : acc_add(r_ov_sum, mul_p);
                ALU_FIN: begin
                    if (out_load) begin
                        n_ch_sum = '0;
                        n_ov_sum = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_sum <= '0;
            r_ov_sum <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ch_sum <= n_ch_sum;
            r_ov_sum <= n_ov_sum;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch <= r_ch_sum;
            r_out_ov <= r_ov_sum;
        end
    end

    assign o_valid           = r_ovalid;
    assign o_channel_volume  = $signed(r_out_ch);
    assign o_overland_volume = $signed(r_out_ov);

`include "grid_water_volume_accumulator_macros.svh"

    `GWVA_ASSERT_NEXT(a_busy_after_accept, in_accept, o_stall, "accepted cell did not start")
    `GWVA_ASSERT_NEXT(a_sums_cleared, out_load, (r_ch_sum == '0) && (r_ov_sum == '0), "sums not cleared after result")
    `GWVA_ASSERT_IMPL(a_chan_nonneg, 1'b1, !r_ch_sum[63], "channel sum went negative")

endmodule

`default_nettype wire
